@@ sv/grouping_list_table_macros.svh @@
// assertion helpers for the grouping list table
`ifndef GROUPING_LIST_TABLE_MACROS_SVH
`define GROUPING_LIST_TABLE_MACROS_SVH

// check a property on every edge outside reset
`define GLT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("grouping list table check failed");

// check a property on every edge, reset included
`define GLT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("grouping list table reset check failed");

`endif

@@ sv/glt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package glt_pkg;

  // table geometry
  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // result field widths
  localparam int ELEM_W   = 32;
  localparam int POS_W    = 5;
  localparam int ECNT_W   = 6;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  // status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_NOTFOUND = 2'd2;
  localparam logic [1:0] STS_EMPTY    = 2'd3;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DUMP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic dump_emit;
  } glt_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       out_free;
    logic       dump_end;
  } glt_sts_t;

  // table index to the 5-bit position field
  function automatic logic [POS_W-1:0] pos_field(input idx_t idx);
    logic [IDX_W+POS_W-1:0] wide;
    wide = {{POS_W{1'b0}}, idx};
    return wide[POS_W-1:0];
  endfunction

  // entry count to the 6-bit count field
  function automatic logic [ECNT_W-1:0] cnt_field(input cnt_t cnt);
    logic [CNT_W+ECNT_W-1:0] wide;
    wide = {{ECNT_W{1'b0}}, cnt};
    return wide[ECNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/glt_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface glt_in_if;
  logic           valid;
  logic           ready;
  logic [1:0]     command;
  glt_pkg::elem_t value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

@@ sv/glt_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface glt_out_if;
  logic                       valid;
  logic                       ready;
  glt_pkg::elem_t             element;
  logic [glt_pkg::POS_W-1:0]  position;
  logic [1:0]                 status;
  logic [glt_pkg::ECNT_W-1:0] entry_count;
  logic                       last;

  modport source (output valid, output element, output position, output status,
                  output entry_count, output last, input ready);
  modport sink   (input valid, input element, input position, input status,
                  input entry_count, input last, output ready);
endinterface

`default_nettype wire

@@ sv/glt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module glt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  glt_pkg::glt_sts_t sts,
  output glt_pkg::glt_ctl_t ctl
);

  glt_pkg::state_t state_r;
  glt_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= glt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      glt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = glt_pkg::ST_EXEC;
        end
      end
      glt_pkg::ST_EXEC: begin
        case (sts.op)
          glt_pkg::CMD_INSERT, glt_pkg::CMD_REMOVE: begin
            if (sts.out_free) begin
              ctl.exec  = 1'b1;
              state_nxt = glt_pkg::ST_IDLE;
            end
          end
          glt_pkg::CMD_DUMP: begin
            state_nxt = glt_pkg::ST_DUMP;
          end
          default: begin
            // unused code: no result
            state_nxt = glt_pkg::ST_IDLE;
          end
        endcase
      end
      glt_pkg::ST_DUMP: begin
        if (sts.out_free) begin
          ctl.dump_emit = 1'b1;
          if (sts.dump_end) begin
            state_nxt = glt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = glt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/glt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module glt_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [1:0]                 in_command,
  input  glt_pkg::elem_t             in_value,
  input  glt_pkg::glt_ctl_t          ctl,
  output glt_pkg::glt_sts_t          sts,
  input  logic                       out_ready,
  output logic                       out_valid,
  output glt_pkg::elem_t             out_element,
  output logic [glt_pkg::POS_W-1:0]  out_position,
  output logic [1:0]                 out_status,
  output logic [glt_pkg::ECNT_W-1:0] out_entry_count,
  output logic                       out_last
);

  localparam int CAP = glt_pkg::CAPACITY;

  glt_pkg::elem_t entries_r [CAP];
  glt_pkg::elem_t entries_nxt [CAP];
  glt_pkg::cnt_t  count_r;
  glt_pkg::cnt_t  count_nxt;

  // latched item and search result
  logic [1:0]     op_r;
  glt_pkg::elem_t value_r;
  logic           found_r;
  glt_pkg::idx_t  hit_idx_r;
  glt_pkg::idx_t  dump_idx_r;

  // output register
  logic                       out_valid_r;
  glt_pkg::elem_t             out_element_r;
  logic [glt_pkg::POS_W-1:0]  out_position_r;
  logic [1:0]                 out_status_r;
  logic [glt_pkg::ECNT_W-1:0] out_entry_count_r;
  logic                       out_last_r;

  logic           hit_any;
  glt_pkg::idx_t  hit_idx;
  logic           full;
  glt_pkg::idx_t  ins_pos;
  logic           out_free;
  logic           dump_end;

  // parallel compare against the held entries, first match wins
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int j = CAP - 1; j >= 0; j--) begin
      if (entries_r[j] == in_value && glt_pkg::CNT_W'(j) < count_r) begin
        hit_any = 1'b1;
        hit_idx = glt_pkg::IDX_W'(j);
      end
    end
  end

  assign full    = (count_r >= glt_pkg::CNT_W'(CAP));
  assign ins_pos = found_r ? hit_idx_r + glt_pkg::IDX_W'(1) : glt_pkg::IDX_W'(count_r);

  // single shift step: open a gap on insert, close it on remove
  always_comb begin
    count_nxt = count_r;
    for (int j = 0; j < CAP; j++) begin
      entries_nxt[j] = entries_r[j];
    end
    if (op_r == glt_pkg::CMD_INSERT && !full) begin
      count_nxt = count_r + glt_pkg::CNT_W'(1);
      for (int j = 0; j < CAP; j++) begin
        if (glt_pkg::IDX_W'(j) == ins_pos) begin
          entries_nxt[j] = value_r;
        end else if (j > 0) begin
          if (glt_pkg::IDX_W'(j) > ins_pos) begin
            entries_nxt[j] = entries_r[j-1];
          end
        end
      end
    end else if (op_r == glt_pkg::CMD_REMOVE && found_r) begin
      count_nxt = count_r - glt_pkg::CNT_W'(1);
      for (int j = 0; j < CAP - 1; j++) begin
        if (glt_pkg::IDX_W'(j) >= hit_idx_r) begin
          entries_nxt[j] = entries_r[j+1];
        end
      end
    end
  end

  // table storage, contents undefined until written
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      for (int j = 0; j < CAP; j++) begin
        entries_r[j] <= entries_nxt[j];
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.exec) begin
      count_r <= count_nxt;
    end
  end

  // item latch with search result
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r       <= in_command;
      value_r    <= in_value;
      found_r    <= hit_any;
      hit_idx_r  <= hit_idx;
      dump_idx_r <= '0;
    end else if (ctl.dump_emit) begin
      dump_idx_r <= dump_idx_r + glt_pkg::IDX_W'(1);
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign dump_end = (count_r == '0) ||
                    (glt_pkg::CNT_W'(dump_idx_r) + glt_pkg::CNT_W'(1) == count_r);

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.exec || ctl.dump_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      out_element_r     <= value_r;
      out_last_r        <= 1'b1;
      out_entry_count_r <= glt_pkg::cnt_field(count_nxt);
      if (op_r == glt_pkg::CMD_INSERT) begin
        if (full) begin
          out_position_r <= '0;
          out_status_r   <= glt_pkg::STS_FULL;
        end else begin
          out_position_r <= glt_pkg::pos_field(ins_pos);
          out_status_r   <= glt_pkg::STS_OK;
        end
      end else begin
        if (found_r) begin
          out_position_r <= glt_pkg::pos_field(hit_idx_r);
          out_status_r   <= glt_pkg::STS_OK;
        end else begin
          out_position_r <= '0;
          out_status_r   <= glt_pkg::STS_NOTFOUND;
        end
      end
    end else if (ctl.dump_emit) begin
      out_last_r        <= dump_end;
      out_entry_count_r <= glt_pkg::cnt_field(count_r);
      if (count_r == '0) begin
        out_element_r  <= '0;
        out_position_r <= '0;
        out_status_r   <= glt_pkg::STS_EMPTY;
      end else begin
        out_element_r  <= entries_r[dump_idx_r];
        out_position_r <= glt_pkg::pos_field(dump_idx_r);
        out_status_r   <= glt_pkg::STS_OK;
      end
    end
  end

  // status to controller
  assign sts.op       = op_r;
  assign sts.out_free = out_free;
  assign sts.dump_end = dump_end;

  assign out_valid       = out_valid_r;
  assign out_element     = out_element_r;
  assign out_position    = out_position_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

@@ sv/grouping_list_table.sv @@
// insert and remove: item and search result latched, then result registered when output free
// dump: one table entry a cycle while the output is free; empty list: one empty result
// the compare-and-latch step is followed by the single shift step on the table
// results wait in an output register; a new item is taken while one is pending
// synchronous active-low reset empties the list and clears out_valid; table data undefined
`timescale 1ns / 1ps
`default_nettype none

module grouping_list_table (
  input  logic     clk,
  input  logic     rst_n,
  glt_in_if.sink   in_chan,
  glt_out_if.source out_chan
);

  glt_pkg::glt_ctl_t ctl;
  glt_pkg::glt_sts_t sts;

  // sequencer
  glt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // table, search and result register
  glt_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_chan.command),
    .in_value        (in_chan.value),
    .ctl             (ctl),
    .sts             (sts),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_element     (out_chan.element),
    .out_position    (out_chan.position),
    .out_status      (out_chan.status),
    .out_entry_count (out_chan.entry_count),
    .out_last        (out_chan.last)
  );

endmodule

`default_nettype wire

@@ sv/glt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "grouping_list_table_macros.svh"

module glt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input glt_pkg::elem_t             element,
  input logic [glt_pkg::POS_W-1:0]  position,
  input logic [1:0]                 status,
  input logic [glt_pkg::ECNT_W-1:0] entry_count,
  input logic                       last
);

  // a stalled result holds
  `GLT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(element) && $stable(position) && $stable(status) && $stable(last))

  // one item at a time: no second item right after one is taken
  `GLT_ASSERT(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready)

  // dropped or missing values report position zero and close the item
  `GLT_ASSERT(a_err_shape, clk, rst_n, out_valid && (status == glt_pkg::STS_FULL || status == glt_pkg::STS_NOTFOUND) |-> position == '0 && last)

  // empty dump is a single zero result
  `GLT_ASSERT(a_empty_dump, clk, rst_n, out_valid && status == glt_pkg::STS_EMPTY |-> last && element == '0 && entry_count == '0)

  // reset drops any pending result
  `GLT_ASSERT_ALWAYS(a_reset_out, clk, !rst_n |=> !out_valid)

endmodule

bind grouping_list_table glt_checker u_glt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .element     (out_chan.element),
  .position    (out_chan.position),
  .status      (out_chan.status),
  .entry_count (out_chan.entry_count),
  .last        (out_chan.last)
);

`default_nettype wire

@@ bench/glt_list_checker.sv @@
`timescale 1ns / 1ps

module glt_list_checker (
  input  logic clk,
  input  logic rst_n,
  glt_in_if    in_mon,
  glt_out_if   out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   results_seen
);
  import glt_pkg::*;

  typedef struct packed {
    elem_t             element;
    logic [POS_W-1:0]  position;
    logic [1:0]        status;
    logic [ECNT_W-1:0] entry_count;
    logic              last;
  } list_result_t;

  // shadow copy of the grouped table
  elem_t          shadow_tbl [CAPACITY];
  int unsigned    shadow_held;
  list_result_t   awaited_results [$];

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
    shadow_held  = 0;
  end

  // first slot holding v, or the fill level when absent
  function automatic int unsigned first_equal(input elem_t v);
    int unsigned k;
    for (k = 0; k < shadow_held; k++) begin
      if (shadow_tbl[k] == v) return k;
    end
    return shadow_held;
  endfunction

  function automatic list_result_t make_result(input elem_t e, input int unsigned pos,
                                               input logic [1:0] sts, input logic lst);
    list_result_t r;
    r.element     = e;
    r.position    = pos[POS_W-1:0];
    r.status      = sts;
    r.entry_count = shadow_held[ECNT_W-1:0];
    r.last        = lst;
    return r;
  endfunction

  // advance the shadow table by one accepted item and queue what it causes
  task automatic apply_command(input logic [1:0] cmd, input elem_t v);
    int unsigned hit;
    int unsigned slot;
    int unsigned k;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_held >= CAPACITY) begin
          awaited_results.push_back(make_result(v, 0, STS_FULL, 1'b1));
        end else begin
          hit  = first_equal(v);
          slot = (hit < shadow_held) ? hit + 1 : shadow_held;
          for (k = shadow_held; k > slot; k--) shadow_tbl[k] = shadow_tbl[k-1];
          shadow_tbl[slot] = v;
          shadow_held++;
          awaited_results.push_back(make_result(v, slot, STS_OK, 1'b1));
        end
      end
      CMD_REMOVE: begin
        hit = first_equal(v);
        if (hit >= shadow_held) begin
          awaited_results.push_back(make_result(v, 0, STS_NOTFOUND, 1'b1));
        end else begin
          for (k = hit; k + 1 < shadow_held; k++) shadow_tbl[k] = shadow_tbl[k+1];
          shadow_held--;
          awaited_results.push_back(make_result(v, hit, STS_OK, 1'b1));
        end
      end
      CMD_DUMP: begin
        if (shadow_held == 0) begin
          awaited_results.push_back(make_result('0, 0, STS_EMPTY, 1'b1));
        end else begin
          for (k = 0; k < shadow_held; k++) begin
            awaited_results.push_back(make_result(shadow_tbl[k], k, STS_OK,
                                                  (k + 1 == shadow_held)));
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_field(input string field, input longint want, input longint seen);
    mismatches++;
    $error("%s: expected %0d, got %0d", field, want, seen);
  endtask

  // compare taken results first, then predict from the taken item
  always @(posedge clk) begin
    list_result_t want_r;
    if (!rst_n) begin
      shadow_held = 0;
      awaited_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          $error("unexpected result: element %0d position %0d status %0d",
                 out_mon.element, out_mon.position, out_mon.status);
        end else begin
          want_r = awaited_results.pop_front();
          if (out_mon.element !== want_r.element)
            report_field("element", want_r.element, out_mon.element);
          if (out_mon.position !== want_r.position)
            report_field("position", want_r.position, out_mon.position);
          if (out_mon.status !== want_r.status)
            report_field("status", want_r.status, out_mon.status);
          if (out_mon.entry_count !== want_r.entry_count)
            report_field("entry_count", want_r.entry_count, out_mon.entry_count);
          if (out_mon.last !== want_r.last)
            report_field("last", want_r.last, out_mon.last);
        end
      end
      if (in_mon.valid && in_mon.ready) apply_command(in_mon.command, in_mon.value);
    end
    outstanding = awaited_results.size();
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import glt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = CAPACITY + 8;
  localparam int IDLE_PCT     = 11;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // clock
  always #1 clk = ~clk;

  glt_in_if  in_bus ();
  glt_out_if out_bus ();

  grouping_list_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  int mismatches;
  int outstanding;
  int results_seen;

  glt_list_checker list_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  bit    idle_on = 1'b1;
  elem_t val_pool [8];
  int    n_items, n_insert, n_remove, n_dump, n_ignored;

  // result side back-pressure
  always @(negedge clk) begin
    out_bus.ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watchdog on cycles with nothing taken on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // offer one item with random gaps in front, return at the next falling edge
  task automatic push_item(input logic [1:0] cmd, input elem_t val);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.command <= cmd;
    in_bus.value   <= val;
    do @(posedge clk); while (!in_bus.ready);
    n_items++;
    case (cmd)
      CMD_INSERT: n_insert++;
      CMD_REMOVE: n_remove++;
      CMD_DUMP:   n_dump++;
      default:    n_ignored++;
    endcase
    @(negedge clk);
  endtask

  // hold off until every predicted result has come back
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // small pool of values so that equal entries group up
  task automatic refresh_pool();
    int k;
    val_pool[0] = 32'sh8000_0000;
    val_pool[1] = 32'sh7fff_ffff;
    val_pool[2] = '0;
    val_pool[3] = -32'sd1;
    for (k = 4; k < 8; k++) val_pool[k] = $urandom;
  endtask

  function automatic elem_t pick_value();
    if ($urandom_range(0, 99) < 90) return val_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // one random item, weighted by percentages for insert, remove and dump
  task automatic random_item(input int ins_pct, input int rem_pct, input int dump_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct)
      push_item(CMD_INSERT, pick_value());
    else if (roll < ins_pct + rem_pct)
      push_item(CMD_REMOVE, pick_value());
    else if (roll < ins_pct + rem_pct + dump_pct)
      push_item(CMD_DUMP, $urandom);
    else
      push_item(CMD_UNUSED, $urandom);
  endtask

  // fill towards capacity, then drain back down
  task automatic fill_drain_round();
    int k;
    refresh_pool();
    for (k = 0; k < 55; k++) random_item(84, 6, 8);
    for (k = 0; k < 45; k++) random_item(10, 76, 12);
  endtask

  // stimulus
  initial begin
    in_bus.valid   = 1'b0;
    in_bus.command = CMD_INSERT;
    in_bus.value   = '0;
    out_bus.ready  = 1'b0;
    n_items = 0; n_insert = 0; n_remove = 0; n_dump = 0; n_ignored = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table cases, grouping, extremes, unused code
    push_item(CMD_DUMP,   '0);
    push_item(CMD_REMOVE, 32'sh8000_0000);
    push_item(CMD_INSERT, 32'sh7fff_ffff);
    push_item(CMD_INSERT, 32'sh8000_0000);
    push_item(CMD_INSERT, '0);
    push_item(CMD_INSERT, 32'sh7fff_ffff);
    push_item(CMD_INSERT, -32'sd1);
    push_item(CMD_INSERT, '0);
    push_item(CMD_INSERT, 32'sh8000_0000);
    push_item(CMD_REMOVE, 32'sd12345);
    push_item(CMD_REMOVE, 32'sh8000_0000);
    push_item(CMD_UNUSED, -32'sd1);
    push_item(CMD_DUMP,   -32'sd1);
    push_item(CMD_REMOVE, 32'sh7fff_ffff);
    push_item(CMD_REMOVE, -32'sd1);
    push_item(CMD_DUMP,   '0);
    push_item(CMD_INSERT, 32'sh5555_5555);
    push_item(CMD_INSERT, 32'shaaaa_aaaa);
    push_item(CMD_DUMP,   '0);
    wait_drained();

    // random rounds, the middle one with no idling on either side
    fill_drain_round();
    wait_drained();
    idle_on = 1'b0;
    fill_drain_round();
    idle_on = 1'b1;
    fill_drain_round();

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d items: %0d inserts, %0d removes, %0d dumps, %0d unused codes",
             n_items, n_insert, n_remove, n_dump, n_ignored);
    $display("checked %0d results over fill and drain rounds with random stalls",
             results_seen);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/glt_pkg.sv
sv/glt_in_if.sv
sv/glt_out_if.sv
sv/glt_ctrl.sv
sv/glt_datapath.sv
sv/grouping_list_table.sv
sv/glt_checker.sv
bench/glt_list_checker.sv
bench/tb_top.sv
